[design/tbfdc_pkg.sv]
// shared types, codes and constants of the tilt beacon frame decoder
`default_nettype none

package tbfdc_pkg;

	localparam int ENTRIES_DEF = 8;

	localparam int MAC_W     = 48;
	localparam int TIME_W    = 32;
	localparam int STALE_W   = 23;
	localparam int VALUE_W   = 17;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 3;
	localparam int CHAN_W    = 3;
	localparam int BIDX_W    = 5;
	localparam int AXES_W    = 48;
	localparam int NUM_AXES  = 6;

	localparam logic [STALE_W-1:0] STALE_RESET = 23'd60000;

	localparam logic [15:0] COMPANY_TILT  = 16'hFFFF;
	localparam logic [7:0]  PROTO_MARK    = 8'h01;
	localparam logic [7:0]  TYPE_MARK     = 8'hA7;
	localparam logic [7:0]  ANGLE_UNKNOWN = 8'hFF;

	// byte positions inside the manufacturer data, company prefix included
	localparam logic [BIDX_W-1:0] BI_PROTO   = 5'd2;
	localparam logic [BIDX_W-1:0] BI_FLAGS   = 5'd3;
	localparam logic [BIDX_W-1:0] BI_ANGLE   = 5'd4;
	localparam logic [BIDX_W-1:0] BI_BATT_LO = 5'd5;
	localparam logic [BIDX_W-1:0] BI_BATT_HI = 5'd6;
	localparam logic [BIDX_W-1:0] BI_TYPE    = 5'd8;
	localparam logic [BIDX_W-1:0] BI_AXES0   = 5'd9;
	localparam logic [BIDX_W-1:0] BI_LAST    = 5'd14;
	localparam logic [BIDX_W-1:0] BI_SAT     = 5'd31;

	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_NOT_OURS = 3'd0;
	localparam logic [STATUS_W-1:0] ST_STORED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_DATA  = 3'd4;

	localparam logic [CHAN_W-1:0] CH_ANGLE = 3'd0;
	localparam logic [CHAN_W-1:0] CH_TILT  = 3'd1;
	localparam logic [CHAN_W-1:0] CH_BATT  = 3'd2;
	localparam logic [CHAN_W-1:0] CH_X     = 3'd3;
	localparam logic [CHAN_W-1:0] CH_Y     = 3'd4;
	localparam logic [CHAN_W-1:0] CH_Z     = 3'd5;

	typedef struct packed {
		logic [7:0]        angle;
		logic              tilted;
		logic [15:0]       battery;
		logic [AXES_W-1:0] axes;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic take;    // item accepted this cycle
		logic commit;  // frame end: update table, load result, clear staging
		logic rd;      // query: read entry data
		logic finish;  // query: load result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_result;  // incoming item yields a result
		logic is_query;    // held item is a query
	} sts_t;

endpackage

`default_nettype wire

[design/tbfdc_ctrl.sv]
// sequencing state machine of the frame decoder
`default_nettype none

module tbfdc_ctrl
	import tbfdc_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  wire  rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_ENC,
		S_ACT,
		S_READ
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   take;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign take      = req_valid && (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.take   = take;
		cmd.commit = (state_q == S_ACT) && !sts.is_query && out_free;
		cmd.rd     = (state_q == S_ACT) && sts.is_query;
		cmd.finish = (state_q == S_READ) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take && sts.has_result)
						state_q <= S_CMP;
				end
				S_CMP: state_q <= S_ENC;
				S_ENC: state_q <= S_ACT;
				S_ACT: begin
					if (sts.is_query) begin
						state_q <= S_READ;
					end else if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/tbfdc_dp.sv]
// staging registers, address table, entry memory and result register
`default_nettype none

module tbfdc_dp
	import tbfdc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
)(
	input  wire                       clk,
	input  wire                       arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  wire                       cfg_we,
	input  wire  [STALE_W-1:0]        cfg_data,
	input  wire                       req_type,
	input  wire  [MAC_W-1:0]          mac,
	input  wire  [15:0]               company,
	input  wire  [7:0]                data_byte,
	input  wire                       last_byte,
	input  wire  [CHAN_W-1:0]         channel,
	input  wire  [TIME_W-1:0]         now_ms,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] value,
	output logic [SLOT_W-1:0]         slot
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// configuration
	logic [STALE_W-1:0] stale_q;

	// held request
	logic               type_q;
	logic [MAC_W-1:0]   mac_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [TIME_W-1:0]  now_q;
	logic               claim_q;

	// frame staging
	logic [BIDX_W-1:0]  bidx_q;
	logic               good_q;
	logic               tilt_q;
	logic [7:0]         angle_q;
	logic [15:0]        batt_q;
	logic [AXES_W-1:0]  axes_q;
	logic               good_next;

	// table
	logic [CNT_W-1:0]   fill_q;
	logic [MAC_W-1:0]   entry_mac_q [ENTRIES];
	entry_t             entry_mem [ENTRIES];
	logic [ENTRIES-1:0] match_s1;
	logic               hit_s2;
	logic [IDX_W-1:0]   idx_s2;
	entry_t             rd_s3;
	logic               enc_hit;
	logic [IDX_W-1:0]   enc_idx;
	logic               full;
	logic               do_write;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_entry;

	// result
	logic [STATUS_W-1:0]       status_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [IDX_W+SLOT_W-1:0]   slot_ext;
	logic [TIME_W-1:0]         age;
	logic                      fresh;
	logic                      chan_ok;
	logic [VALUE_W-1:0]        chan_val;

	assign status = status_q;
	assign value  = value_q;
	assign slot   = slot_q;

	assign sts.has_result = (req_type == REQ_QUERY) || last_byte;
	assign sts.is_query   = (type_q == REQ_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stale_q <= STALE_RESET;
		else if (cfg_we)
			stale_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			type_q <= req_type;
			mac_q  <= mac;
			chan_q <= channel;
			now_q  <= now_ms;
		end
	end

	always_comb begin
		good_next = good_q;
		if (bidx_q == BI_PROTO && data_byte != PROTO_MARK)
			good_next = 1'b0;
		if (bidx_q == BI_TYPE && data_byte != TYPE_MARK)
			good_next = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bidx_q  <= '0;
			good_q  <= 1'b1;
			tilt_q  <= 1'b0;
			angle_q <= '0;
			batt_q  <= '0;
			axes_q  <= '0;
			claim_q <= 1'b0;
		end else if (cmd.commit) begin
			bidx_q  <= '0;
			good_q  <= 1'b1;
			tilt_q  <= 1'b0;
			angle_q <= '0;
			batt_q  <= '0;
			axes_q  <= '0;
		end else if (cmd.take && req_type == REQ_BYTE) begin
			good_q <= good_next;
			if (bidx_q == BI_FLAGS)
				tilt_q <= data_byte[0];
			if (bidx_q == BI_ANGLE)
				angle_q <= data_byte;
			if (bidx_q == BI_BATT_LO)
				batt_q[7:0] <= data_byte;
			if (bidx_q == BI_BATT_HI)
				batt_q[15:8] <= data_byte;
			for (int k = 0; k < NUM_AXES; k++) begin
				if (bidx_q == BI_AXES0 + BIDX_W'(k))
					axes_q[8*k +: 8] <= data_byte;
			end
			if (bidx_q != BI_SAT)
				bidx_q <= bidx_q + 1'b1;
			claim_q <= (company == COMPANY_TILT) && good_next && (bidx_q == BI_LAST);
		end
	end

	// parallel address compare over filled entries
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++)
			match_s1[i] <= (fill_q > CNT_W'(i)) && (entry_mac_q[i] == mac_q);
	end

	always_comb begin
		enc_hit = 1'b0;
		enc_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				enc_hit = 1'b1;
				enc_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= enc_hit;
		idx_s2 <= enc_idx;
	end

	assign full     = (fill_q == CNT_W'(ENTRIES));
	assign do_write = cmd.commit && claim_q && (hit_s2 || !full);
	assign wr_idx   = hit_s2 ? idx_s2 : fill_q[IDX_W-1:0];

	always_comb begin
		wr_entry.angle   = angle_q;
		wr_entry.tilted  = tilt_q;
		wr_entry.battery = batt_q;
		wr_entry.axes    = axes_q;
		wr_entry.stamp   = now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (do_write && !hit_s2)
			fill_q <= fill_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (do_write && !hit_s2)
			entry_mac_q[wr_idx] <= mac_q;
	end

	always_ff @(posedge clk) begin
		if (do_write)
			entry_mem[wr_idx] <= wr_entry;
		if (cmd.rd)
			rd_s3 <= entry_mem[idx_s2];
	end

	// query evaluation on the read entry
	assign age   = now_q - rd_s3.stamp;
	assign fresh = age < {{(TIME_W-STALE_W){1'b0}}, stale_q};

	always_comb begin
		chan_ok  = 1'b1;
		chan_val = '0;
		case (chan_q)
			CH_ANGLE: begin
				chan_ok  = (rd_s3.angle != ANGLE_UNKNOWN);
				chan_val = {9'd0, rd_s3.angle};
			end
			CH_TILT: chan_val = {16'd0, rd_s3.tilted};
			CH_BATT: chan_val = {1'b0, rd_s3.battery};
			CH_X:    chan_val = {rd_s3.axes[15], rd_s3.axes[15:0]};
			CH_Y:    chan_val = {rd_s3.axes[31], rd_s3.axes[31:16]};
			CH_Z:    chan_val = {rd_s3.axes[47], rd_s3.axes[47:32]};
			default: chan_ok = 1'b0;
		endcase
	end

	always_comb begin
		slot_ext = '0;
		slot_ext[IDX_W-1:0] = cmd.finish ? idx_s2 : wr_idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			value_q <= '0;
			if (!claim_q) begin
				status_q <= ST_NOT_OURS;
				slot_q   <= '0;
			end else if (do_write) begin
				status_q <= ST_STORED;
				slot_q   <= slot_ext[SLOT_W-1:0];
			end else begin
				status_q <= ST_FULL;
				slot_q   <= '0;
			end
		end else if (cmd.finish) begin
			if (hit_s2 && fresh && chan_ok) begin
				status_q <= ST_READ_OK;
				value_q  <= chan_val;
				slot_q   <= slot_ext[SLOT_W-1:0];
			end else begin
				status_q <= ST_NO_DATA;
				value_q  <= '0;
				slot_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[design/tilt_beacon_frame_decode_cache.sv]
// top level of the tilt beacon frame decoder and reading cache
// channels: request (req_valid/req_stall) carries one frame byte or one channel
// query per item; response (rsp_valid/rsp_stall) carries status, value, slot.
// a frame byte that is not the last is taken and gives no item.
// a response is valid once the last byte of a frame or a query has passed its
// steps: address compare, index encode, then table update or entry memory
// read and evaluate.
// the state machine holds one item at a time: after a last byte or a query the
// next item is taken once it is back in idle; plain bytes can arrive every cycle while idle.
// the response register is reloaded in the cycle an earlier response drains;
// while rsp_stall holds a response, the next result-producing item waits in its
// last step and req_stall stays high until it moves into the response register.
// cfg_data writes the 23-bit stale age limit on cfg_valid, always ready; write
// only while idle. reset empties the table, clears frame staging and sets the
// stale age limit to 60000 ms; no clearing pass is needed.
`default_nettype none

module tilt_beacon_frame_decode_cache
	import tbfdc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
)(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire  [STALE_W-1:0]        cfg_data,
	input  wire                       req_valid,
	output logic                      req_stall,
	input  wire                       req_type,
	input  wire  [MAC_W-1:0]          mac,
	input  wire  [15:0]               company,
	input  wire  [7:0]                data_byte,
	input  wire                       last_byte,
	input  wire  [CHAN_W-1:0]         channel,
	input  wire  [TIME_W-1:0]         now_ms,
	output logic                      rsp_valid,
	input  wire                       rsp_stall,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] value,
	output logic [SLOT_W-1:0]         slot
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tbfdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tbfdc_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.req_type  (req_type),
		.mac       (mac),
		.company   (company),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.channel   (channel),
		.now_ms    (now_ms),
		.status    (status),
		.value     (value),
		.slot      (slot)
	);

endmodule

`default_nettype wire

[tb/sv/tilt_beacon_frame_decode_cache_tb.sv]
// self-checking testbench for the tilt beacon frame decoder and reading cache
module tilt_beacon_frame_decode_cache_tb
	import tbfdc_pkg::*;
();

	localparam int CYCLE_LIMIT = 300000;
	localparam int POOL = 12;
	localparam int PHASE_ITEMS = 150;
	localparam logic [5:0] FRAME_LEN = 6'(BI_LAST) + 6'd1;
	localparam logic [CHAN_W-1:0] CH_SPARE_LO = 3'd6;
	localparam logic [CHAN_W-1:0] CH_SPARE_HI = 3'd7;
	localparam logic [MAC_W-1:0] MAC_MID = 48'hA5A5_5A5A_0F0F;

	typedef struct packed {
		logic              rtype;
		logic [MAC_W-1:0]  mac;
		logic [15:0]       company;
		logic [7:0]        octet;
		logic              lastb;
		logic [CHAN_W-1:0] chan;
		logic [TIME_W-1:0] now;
	} beacon_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
		logic [SLOT_W-1:0]   slot;
	} beacon_rsp_t;

	// one frame or one query of the stimulus plan
	typedef struct packed {
		logic              query;
		logic [MAC_W-1:0]  mac;
		logic [15:0]       company;
		logic [5:0]        len;
		logic [7:0]        proto;
		logic [7:0]        tmark;
		logic [7:0]        flags;
		logic [7:0]        angle;
		logic [15:0]       batt;
		logic [AXES_W-1:0] axes;
		logic [TIME_W-1:0] now;
		logic [CHAN_W-1:0] chan;
		logic              pin;
		beacon_rsp_t       want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	wire cfg_ready;
	logic [STALE_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	wire req_stall;
	logic req_type = 1'b0;
	logic [MAC_W-1:0] mac = '0;
	logic [15:0] company = '0;
	logic [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic [CHAN_W-1:0] channel = '0;
	logic [TIME_W-1:0] now_ms = '0;
	wire rsp_valid;
	logic rsp_stall = 1'b0;
	wire [STATUS_W-1:0] status;
	wire signed [VALUE_W-1:0] value;
	wire [SLOT_W-1:0] slot;

	// cache model
	logic [MAC_W-1:0] tab_mac [ENTRIES_DEF];
	logic [7:0] tab_angle [ENTRIES_DEF];
	logic tab_tilt [ENTRIES_DEF];
	logic [15:0] tab_batt [ENTRIES_DEF];
	logic [AXES_W-1:0] tab_axes [ENTRIES_DEF];
	logic [TIME_W-1:0] tab_stamp [ENTRIES_DEF];
	int fill_cnt = 0;
	int stage_idx = 0;
	bit stage_ok = 1'b1;
	logic [31:0] stage_fields = '0;
	logic [AXES_W-1:0] stage_axes = '0;
	logic [STALE_W-1:0] stale_lim = STALE_RESET;

	beacon_rsp_t expected_rsp [$];
	logic pinned_use = 1'b0;
	beacon_rsp_t pinned_rsp = '0;

	logic [MAC_W-1:0] mac_pool [POOL];
	logic [TIME_W-1:0] clock_ms = '0;
	bit calm_src = 1'b0;
	bit calm_snk = 1'b0;
	int sink_wait = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int n_stored = 0, n_read_ok = 0, n_full = 0, n_no_data = 0, n_not_ours = 0;

	tilt_beacon_frame_decode_cache dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_data,
		.req_valid, .req_stall, .req_type, .mac, .company, .data_byte, .last_byte,
		.channel, .now_ms,
		.rsp_valid, .rsp_stall, .status, .value, .slot
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tilt_beacon_frame_decode_cache_tb failed");
			$finish;
		end
	end

	function automatic int lookup_mac(input logic [MAC_W-1:0] m);
		for (int i = 0; i < fill_cnt && i < ENTRIES_DEF; i++)
			if (tab_mac[i] == m)
				return i;
		return -1;
	endfunction

	// advances the cache model by one item, queues the result it yields
	task automatic decode_item(input beacon_req_t r, input logic pin, input beacon_rsp_t pin_rsp);
		beacon_rsp_t res;
		int pos;
		int hit;
		logic [TIME_W-1:0] age;
		res = '0;
		if (r.rtype == REQ_BYTE) begin
			pos = stage_idx;
			if (pos == int'(BI_PROTO) && r.octet != PROTO_MARK)
				stage_ok = 1'b0;
			if (pos == int'(BI_TYPE) && r.octet != TYPE_MARK)
				stage_ok = 1'b0;
			if (pos >= int'(BI_FLAGS) && pos <= int'(BI_BATT_HI))
				stage_fields[(pos - int'(BI_FLAGS)) * 8 +: 8] = r.octet;
			if (pos >= int'(BI_AXES0) && pos <= int'(BI_LAST))
				stage_axes[(pos - int'(BI_AXES0)) * 8 +: 8] = r.octet;
			if (stage_idx < int'(BI_SAT))
				stage_idx++;
			if (!r.lastb)
				return;
			res.status = ST_NOT_OURS;
			if (r.company == COMPANY_TILT && stage_ok && pos == int'(BI_LAST)) begin
				hit = lookup_mac(r.mac);
				if (hit < 0 && fill_cnt < ENTRIES_DEF) begin
					hit = fill_cnt;
					fill_cnt++;
					tab_mac[hit] = r.mac;
				end
				if (hit < 0) begin
					res.status = ST_FULL;
				end else begin
					tab_tilt[hit] = stage_fields[0];
					tab_angle[hit] = stage_fields[15:8];
					tab_batt[hit] = stage_fields[31:16];
					tab_axes[hit] = stage_axes;
					tab_stamp[hit] = r.now;
					res.status = ST_STORED;
					res.slot = 3'(hit);
				end
			end
			stage_idx = 0;
			stage_ok = 1'b1;
			stage_fields = '0;
			stage_axes = '0;
		end else begin
			res.status = ST_NO_DATA;
			hit = lookup_mac(r.mac);
			if (hit >= 0) begin
				age = r.now - tab_stamp[hit];
				if (age < 32'(stale_lim)) begin
					case (r.chan)
					CH_ANGLE: begin
						if (tab_angle[hit] != ANGLE_UNKNOWN) begin
							res.value = 17'(tab_angle[hit]);
							res.status = ST_READ_OK;
						end
					end
					CH_TILT: begin
						res.value = 17'(tab_tilt[hit]);
						res.status = ST_READ_OK;
					end
					CH_BATT: begin
						res.value = 17'(tab_batt[hit]);
						res.status = ST_READ_OK;
					end
					CH_X, CH_Y, CH_Z: begin
						// 16-bit axis sign-extended into the value field
						pos = 16 * (int'(r.chan) - int'(CH_X));
						res.value = {tab_axes[hit][pos + 15], tab_axes[hit][pos +: 16]};
						res.status = ST_READ_OK;
					end
					default: ;
					endcase
				end
				if (res.status == ST_READ_OK)
					res.slot = 3'(hit);
			end
		end
		expected_rsp.push_back(pin ? pin_rsp : res);
	endtask

	always @(posedge clk)
		if (arst_n && req_valid && !req_stall)
			decode_item(beacon_req_t'{req_type, mac, company, data_byte, last_byte, channel,
				now_ms}, pinned_use, pinned_rsp);

	always @(posedge clk) begin : result_check
		beacon_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("result with none expected: status %0d value %0d slot %0d",
					status, value, slot);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value), value);
					fail_count++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					fail_count++;
				end
				results_checked++;
				case (want.status)
				ST_STORED: n_stored++;
				ST_READ_OK: n_read_ok++;
				ST_FULL: n_full++;
				ST_NO_DATA: n_no_data++;
				default: n_not_ours++;
				endcase
			end
			sink_wait = calm_snk ? 0 : $urandom_range(0, 4);
		end else if (rsp_valid && sink_wait > 0) begin
			sink_wait--;
		end
		rsp_stall <= (sink_wait != 0);
	end

	task automatic put_item(input beacon_req_t r, input logic pin, input beacon_rsp_t pin_rsp);
		int gap;
		req_valid <= 1'b1;
		req_type <= r.rtype;
		mac <= r.mac;
		company <= r.company;
		data_byte <= r.octet;
		last_byte <= r.lastb;
		channel <= r.chan;
		now_ms <= r.now;
		pinned_use <= pin;
		pinned_rsp <= pin_rsp;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		gap = calm_src ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_stale(input logic [STALE_W-1:0] v);
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		// plain bytes may still be in flight
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		stale_lim = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [MAC_W-1:0] pick_mac();
		if ($urandom_range(0, 9) == 0)
			return 48'({$urandom, $urandom});
		return mac_pool[$urandom_range(0, POOL - 1)];
	endfunction

	function automatic logic [7:0] frame_octet(input plan_row_t r, input int k);
		case (k)
		0, 1: return COMPANY_TILT[7:0];
		int'(BI_PROTO): return r.proto;
		int'(BI_FLAGS): return r.flags;
		int'(BI_ANGLE): return r.angle;
		int'(BI_BATT_LO): return r.batt[7:0];
		int'(BI_BATT_HI): return r.batt[15:8];
		int'(BI_TYPE): return r.tmark;
		default: begin
			if (k >= int'(BI_AXES0) && k <= int'(BI_LAST))
				return r.axes[(k - int'(BI_AXES0)) * 8 +: 8];
			return 8'($urandom);
		end
		endcase
	endfunction

	function automatic plan_row_t tilt_frame(input logic [MAC_W-1:0] m, input logic [7:0] flags,
		input logic [7:0] angle, input logic [15:0] batt, input logic [AXES_W-1:0] axes,
		input logic [TIME_W-1:0] t);
		plan_row_t r;
		r = '0;
		r.mac = m;
		r.company = COMPANY_TILT;
		r.len = FRAME_LEN;
		r.proto = PROTO_MARK;
		r.tmark = TYPE_MARK;
		r.flags = flags;
		r.angle = angle;
		r.batt = batt;
		r.axes = axes;
		r.now = t;
		return r;
	endfunction

	function automatic plan_row_t query_op(input logic [MAC_W-1:0] m, input logic [CHAN_W-1:0] ch,
		input logic [TIME_W-1:0] t);
		plan_row_t r;
		r = '0;
		r.query = 1'b1;
		r.mac = m;
		r.chan = ch;
		r.now = t;
		return r;
	endfunction

	function automatic plan_row_t pin_result(input plan_row_t r, input logic [STATUS_W-1:0] st,
		input logic [VALUE_W-1:0] val, input logic [SLOT_W-1:0] sl);
		r.pin = 1'b1;
		r.want = '{st, val, sl};
		return r;
	endfunction

	function automatic plan_row_t rand_op();
		plan_row_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			clock_ms += 0;
		else if (pick < 80)
			clock_ms += $urandom_range(1, 100);
		else if (pick < 95)
			clock_ms += $urandom_range(1, 70000);
		else
			clock_ms = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r = query_op(pick_mac(), 3'($urandom_range(0, 7)), clock_ms);
		end else begin
			r = tilt_frame(pick_mac(), 8'($urandom),
				($urandom_range(0, 9) == 0) ? ANGLE_UNKNOWN : 8'($urandom),
				16'($urandom), 48'({$urandom, $urandom}), clock_ms);
			// broken frames
			if (pick >= 85) begin
				case ($urandom_range(0, 3))
				0: r.company = 16'($urandom);
				1: r.len = 6'($urandom_range(1, 47));
				2: r.proto = 8'($urandom);
				default: r.tmark = 8'($urandom);
				endcase
			end
		end
		return r;
	endfunction

	// a frame goes out byte by byte; with mix set, queries may cut in between bytes
	task automatic play_op(input plan_row_t r, input bit mix);
		beacon_req_t it;
		int k;
		if (r.query) begin
			it = '{REQ_QUERY, r.mac, 16'($urandom), 8'($urandom), 1'($urandom), r.chan, r.now};
			put_item(it, r.pin, r.want);
		end else begin
			for (k = 0; k < int'(r.len); k++) begin
				if (mix && $urandom_range(0, 9) == 0) begin
					it = '{REQ_QUERY, pick_mac(), 16'($urandom), 8'($urandom), 1'($urandom),
						3'($urandom), clock_ms};
					put_item(it, 1'b0, '0);
				end
				if (k == int'(r.len) - 1)
					it = '{REQ_BYTE, r.mac, r.company, frame_octet(r, k), 1'b1, 3'($urandom),
						r.now};
				else
					it = '{REQ_BYTE, 48'({$urandom, $urandom}), 16'($urandom), frame_octet(r, k),
						1'b0, 3'($urandom), $urandom};
				put_item(it, r.pin && k == int'(r.len) - 1, r.want);
			end
		end
	endtask

	initial begin : stimulus
		plan_row_t plan [$];
		plan_row_t fr;
		logic [STALE_W-1:0] stale_plan [5];
		int ch;
		int p;
		int phase_base;
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		mac_pool[2] = MAC_MID;
		for (p = 3; p < POOL; p++)
			mac_pool[p] = 48'({$urandom, $urandom});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(pin_result(query_op('1, CH_ANGLE, 32'd100), ST_NO_DATA, '0, '0));
		plan.push_back(pin_result(tilt_frame('1, 8'h01, 8'd45, 16'hFFFF,
			{16'h8000, 16'h7FFF, 16'hFFFF}, 32'd1000), ST_STORED, '0, 3'd0));
		plan.push_back(pin_result(query_op('1, CH_ANGLE, 32'd1000), ST_READ_OK, 17'd45, 3'd0));
		for (ch = int'(CH_TILT); ch <= int'(CH_Z); ch++)
			plan.push_back(query_op('1, 3'(ch), 32'd1500));
		plan.push_back(pin_result(query_op('1, CH_SPARE_LO, 32'd1500), ST_NO_DATA, '0, '0));
		plan.push_back(pin_result(query_op('1, CH_SPARE_HI, 32'd1500), ST_NO_DATA, '0, '0));
		// rejected frames, then the same frame whole
		fr = tilt_frame('0, 8'h00, ANGLE_UNKNOWN, 16'h0000, '0, 32'd2000);
		fr.company = 16'hFFFE;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		fr.company = COMPANY_TILT;
		fr.len = FRAME_LEN - 6'd1;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		fr.len = FRAME_LEN + 6'd1;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		// index would wrap back to the last position without saturation
		fr.len = 6'd47;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		fr.len = 6'd1;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		fr.len = FRAME_LEN;
		fr.proto = 8'h02;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		fr.proto = PROTO_MARK;
		fr.tmark = 8'hA6;
		plan.push_back(pin_result(fr, ST_NOT_OURS, '0, '0));
		fr.tmark = TYPE_MARK;
		plan.push_back(pin_result(fr, ST_STORED, '0, 3'd1));
		plan.push_back(pin_result(query_op('0, CH_ANGLE, 32'd2000), ST_NO_DATA, '0, '0));
		plan.push_back(query_op('0, CH_BATT, 32'd2000));
		// age equal to the limit is stale, one below is not
		plan.push_back(pin_result(query_op('1, CH_BATT, 32'd61000), ST_NO_DATA, '0, '0));
		plan.push_back(query_op('1, CH_X, 32'd60999));
		plan.push_back(pin_result(tilt_frame(MAC_MID, 8'($urandom), 8'($urandom), 16'($urandom),
			48'({$urandom, $urandom}), 32'hFFFF_FFF0), ST_STORED, '0, 3'd2));
		plan.push_back(query_op(MAC_MID, CH_Y, 32'h0000_0010));
		plan.push_back(pin_result(tilt_frame('1, 8'hFE, 8'd0, 16'd2950,
			48'({$urandom, $urandom}), 32'd70000), ST_STORED, '0, 3'd0));
		foreach (plan[r])
			play_op(plan[r], 1'b0);

		stale_plan = '{23'd4294967, 23'd0, 23'd1, 23'($urandom_range(2, 5000)), STALE_RESET};
		for (p = 0; p < 5; p++) begin
			set_stale(stale_plan[p]);
			calm_src = (p == 1);
			calm_snk = (p == 3);
			phase_base = items_sent;
			while (items_sent - phase_base < PHASE_ITEMS)
				play_op(rand_op(), 1'b1);
		end

		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d items in, %0d results checked: directed table, then five stale limits",
			items_sent, results_checked);
		$display("stored %0d, read %0d, table full %0d, no data %0d, rejected %0d",
			n_stored, n_read_ok, n_full, n_no_data, n_not_ours);
		if (fail_count == 0)
			$display("tilt_beacon_frame_decode_cache_tb passed");
		else
			$display("tilt_beacon_frame_decode_cache_tb failed");
		$finish;
	end

endmodule
